// ===== rtl/core/ppe_pkg.sv =====
`timescale 1ns / 1ps

package ppe_pkg;

  // Table geometry: boundaries first, then c0..cD per segment
  localparam int SEG_COUNT     = 8;
  localparam int COEF_ORDER    = 4;
  localparam int COEF_PER_SEG  = COEF_ORDER + 1;
  localparam int COEF_BASE     = SEG_COUNT + 1;
  localparam int TABLE_DEPTH   = COEF_BASE + SEG_COUNT * COEF_PER_SEG;

  // Field widths fixed by the interface
  localparam int INDEX_W = 6;
  localparam int DATA_W  = 32;
  localparam int Q_SHIFT = 16;

  localparam int SEG_W  = (SEG_COUNT > 1) ? $clog2(SEG_COUNT) : 1;
  localparam int COEF_W = $clog2(COEF_PER_SEG);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  // One transaction as it travels down the cell chain
  typedef struct packed {
    op_t                       op;
    logic [INDEX_W-1:0]        wr_index;
    logic signed [DATA_W-1:0]  wr_value;
    logic signed [DATA_W-1:0]  x;
    logic [SEG_W-1:0]          seg;
    logic                      below;
    logic signed [DATA_W-1:0]  acc;
  } ppe_xact_t;

endpackage

// ===== rtl/core/ppe_select.sv =====
`timescale 1ns / 1ps

module ppe_select (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic                           up_opcode,
  input  logic [ppe_pkg::INDEX_W-1:0]    up_index,
  input  logic signed [ppe_pkg::DATA_W-1:0] up_value,
  input  logic signed [ppe_pkg::DATA_W-1:0] up_x,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output ppe_pkg::ppe_xact_t             dn_xact
);
  import ppe_pkg::*;

  logic signed [DATA_W-1:0] bnd_r [SEG_COUNT];
  logic                     s_valid_r;
  ppe_xact_t                s_xact_r;
  ppe_xact_t                s_xact_nxt;
  logic [SEG_W-1:0]         seg_sel;
  logic                     hit;
  logic                     take;

  assign up_ready = !s_valid_r || dn_ready;
  assign take     = up_valid && up_ready;
  assign dn_valid = s_valid_r;
  assign dn_xact  = s_xact_r;

  // Find the highest segment whose lower boundary is at or below x
  always_comb begin
    seg_sel = '0;
    hit     = 1'b0;
    for (int s = 0; s < SEG_COUNT; s++) begin
      if (up_x >= bnd_r[s]) begin
        seg_sel = SEG_W'(s);
        hit     = 1'b1;
      end
    end
  end

  // Build the transaction; the Horner chain starts from zero
  always_comb begin
    s_xact_nxt          = '0;
    s_xact_nxt.op       = op_t'(up_opcode);
    s_xact_nxt.wr_index = up_index;
    s_xact_nxt.wr_value = up_value;
    s_xact_nxt.x        = up_x;
    s_xact_nxt.seg      = seg_sel;
    s_xact_nxt.below    = !hit;
    s_xact_nxt.acc      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (up_ready) begin
      s_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_xact_r <= s_xact_nxt;
    end
  end

  // Store boundary words; the top boundary is never read and not kept
  always_ff @(posedge clk) begin
    if (take && op_t'(up_opcode) == OP_WRITE) begin
      for (int s = 0; s < SEG_COUNT; s++) begin
        if (int'(up_index) == s) begin
          bnd_r[s] <= up_value;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ppe_horner_cell.sv =====
`timescale 1ns / 1ps

module ppe_horner_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ppe_pkg::COEF_W-1:0]   cell_coef,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  ppe_pkg::ppe_xact_t           up_xact,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output ppe_pkg::ppe_xact_t           dn_xact
);
  import ppe_pkg::*;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Coefficient column of this cell, one word per segment
  logic signed [DATA_W-1:0]       coef_r [SEG_COUNT];

  logic                           m_valid_r;
  ppe_xact_t                      m_xact_r;
  logic signed [2*DATA_W-1:0]     m_prod_r;
  logic                           a_valid_r;
  ppe_xact_t                      a_xact_r;
  ppe_xact_t                      a_xact_nxt;

  logic                           m_ready;
  logic                           a_ready;
  logic signed [DATA_W-1:0]       mul_a;
  logic signed [DATA_W-1:0]       mul_b;
  logic signed [2*DATA_W-Q_SHIFT-1:0] prod_q;
  logic signed [2*DATA_W-Q_SHIFT:0]   sum;
  logic signed [DATA_W-1:0]       coef_rd;
  logic signed [DATA_W-1:0]       acc_nxt;

  assign a_ready  = !a_valid_r || dn_ready;
  assign m_ready  = !m_valid_r || a_ready;
  assign up_ready = m_ready;
  assign dn_valid = a_valid_r;
  assign dn_xact  = a_xact_r;

  assign mul_a = up_xact.acc;
  assign mul_b = up_xact.x;

  // Shift the product, add this cell's coefficient and saturate
  always_comb begin
    coef_rd = coef_r[m_xact_r.seg];
    prod_q  = m_prod_r[2*DATA_W-1:Q_SHIFT];
    sum     = {prod_q[2*DATA_W-Q_SHIFT-1], prod_q}
            + {{(DATA_W-Q_SHIFT+1){coef_rd[DATA_W-1]}}, coef_rd};
    if (sum > (2*DATA_W-Q_SHIFT+1)'(SAT_MAX)) begin
      acc_nxt = SAT_MAX;
    end else if (sum < (2*DATA_W-Q_SHIFT+1)'(SAT_MIN)) begin
      acc_nxt = SAT_MIN;
    end else begin
      acc_nxt = sum[DATA_W-1:0];
    end
    a_xact_nxt     = m_xact_r;
    a_xact_nxt.acc = acc_nxt;
  end

  // Advance the valid bits of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      a_valid_r <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid_r <= up_valid;
      end
      if (a_ready) begin
        a_valid_r <= m_valid_r;
      end
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (m_ready && up_valid) begin
      m_xact_r <= up_xact;
      m_prod_r <= mul_a * mul_b;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (a_ready && m_valid_r) begin
      a_xact_r <= a_xact_nxt;
    end
  end

  // Apply a coefficient write as it passes this cell
  always_ff @(posedge clk) begin
    if (a_ready && m_valid_r && m_xact_r.op == OP_WRITE) begin
      for (int s = 0; s < SEG_COUNT; s++) begin
        if (int'(m_xact_r.wr_index) == COEF_BASE + s * COEF_PER_SEG + int'(cell_coef)) begin
          coef_r[s] <= m_xact_r.wr_value;
        end
      end
    end
  end

endmodule

// ===== rtl/core/piecewise_poly_evaluator.sv =====
`timescale 1ns / 1ps
// An evaluate transaction passes the select register, then a multiply and an
// add register in each Horner cell, then the output register, to out_valid.
// Throughput: one transaction per cycle while out_stall is low; each Horner
// cell is a multiply stage followed by an add stage, and write transactions
// take one slot each. Reset (rst_n low, synchronous) clears all valid bits;
// table words are undefined until written and get no clearing pass.

module piecewise_poly_evaluator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [ppe_pkg::INDEX_W-1:0]       in_table_index,
  input  logic signed [ppe_pkg::DATA_W-1:0] in_table_value,
  input  logic signed [ppe_pkg::DATA_W-1:0] in_x_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ppe_pkg::DATA_W-1:0] out_result_value,
  output logic                              out_below_range
);
  import ppe_pkg::*;

  localparam int NUM_CELLS = COEF_ORDER + 1;

  logic      c_valid [NUM_CELLS+1];
  logic      c_ready [NUM_CELLS+1];
  ppe_xact_t c_xact  [NUM_CELLS+1];
  logic      in_ready;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_result_r;
  logic                     out_below_r;
  logic                     o_ready;
  ppe_xact_t                tail;

  assign in_stall = !in_ready;

  // Segment search and boundary store
  ppe_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_opcode(in_opcode),
    .up_index (in_table_index),
    .up_value (in_table_value),
    .up_x     (in_x_value),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_xact  (c_xact[0])
  );

  // Horner chain, highest coefficient first
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    ppe_horner_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_coef(COEF_W'(COEF_ORDER - i)),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_xact  (c_xact[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_xact  (c_xact[i+1])
    );
  end

  // Output register; drop write transactions here
  assign tail                = c_xact[NUM_CELLS];
  assign o_ready             = !out_valid_r || !out_stall;
  assign c_ready[NUM_CELLS]  = o_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_ready) begin
      out_valid_r <= c_valid[NUM_CELLS] && tail.op == OP_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && c_valid[NUM_CELLS]) begin
      out_result_r <= tail.below ? '0 : tail.acc;
      out_below_r  <= tail.below;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_below_range  = out_below_r;

`ifndef SYNTH
  a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_below_r |-> out_result_r == '0)
    else $error("below-range result is not zero");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while output register is empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
`endif

endmodule
